/* rtl/spp3d_pkg.sv */
// Shared constants and codes for the 3-D segment point projection block.
// No dependencies.
package spp3d_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int T_FRAC_BITS_DEF = 16;
  localparam int DEGEN_RAW       = 4;
  localparam int REG_COUNT       = 6;
  localparam int CFG_IDX_W       = 3;

  typedef enum logic [1:0] {
    FUNC_POINT = 2'd0,
    FUNC_DIR   = 2'd1,
    FUNC_PROJ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_START_Z = 3'd2,
    REG_END_X   = 3'd3,
    REG_END_Y   = 3'd4,
    REG_END_Z   = 3'd5
  } reg_idx_t;

endpackage

/* rtl/segment_point_projection_3d.sv */
// Top level of the 3-D segment point projection block.
// Depends on spp3d_pkg.
//
// Usage: write the segment's start and end points through the cfg_ port
// (index 0..2 start x,y,z; 3..5 end x,y,z) while no item is in flight.
// Each transfer on the in_ channel selects an operation by in_func: point at
// in_param_t, direction, or projection of the query point onto the segment.
// Every input transfer yields exactly one out_ transfer, in order.
// The pipeline is made of an input register,
// a multiply stage, a sum stage, a classify stage and one restoring-division
// stage per fraction bit of res_t. The division chain sets the depth.
// Throughput is one item per cycle while out_stall does not hold the pipeline.
// Reset (rst_n low, synchronous) clears all valid bits and the segment
// registers to zero. When out_stall is high with a result waiting, the whole
// pipeline holds and in_stall rises; nothing is lost or repeated.
module segment_point_projection_3d
  import spp3d_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_func,
  input  logic [T_FRAC_BITS:0]   in_param_t,
  input  logic [COORD_WIDTH-1:0] in_query_x,
  input  logic [COORD_WIDTH-1:0] in_query_y,
  input  logic [COORD_WIDTH-1:0] in_query_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COORD_WIDTH:0]   out_res_x,
  output logic [COORD_WIDTH:0]   out_res_y,
  output logic [COORD_WIDTH:0]   out_res_z,
  output logic [T_FRAC_BITS:0]   out_res_t
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int TW  = T_FRAC_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 2;
  localparam int RW  = SW + 1;
  localparam int MTW = DW + TW + 1;
  localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

  logic [COORD_WIDTH-1:0] cfg_r [REG_COUNT];
  logic adv;

  logic signed [DW-1:0] s_c [3];
  logic signed [DW-1:0] d_c [3];
  logic signed [DW-1:0] w_c [3];
  logic [COORD_WIDTH-1:0] q_in [3];
  logic [TW-1:0] t_sat;

  logic          s1_vld_r;
  func_t         s1_func_r;
  logic [TW-1:0] s1_t_r;
  logic signed [DW-1:0] s1_w_r [3];

  logic          s2_vld_r;
  func_t         s2_func_r;
  logic signed [MTW-1:0] s2_pt_r [3];
  logic signed [PW-1:0]  s2_pw_r [3];
  logic signed [PW-1:0]  s2_dd_r [3];

  logic          s3_vld_r;
  func_t         s3_func_r;
  logic [DW-1:0] s3_res_r [3];
  logic signed [SW-1:0] s3_num_r;
  logic [SW-1:0] s3_vv_r;

  logic [DW-1:0] res_nxt [3];
  logic signed [SW-1:0] num_nxt;
  logic signed [SW-1:0] vv_nxt;

  logic          dv_vld_r [T_FRAC_BITS+1];
  logic          dv_fix_r [T_FRAC_BITS+1];
  logic [TW-1:0] dv_q_r   [T_FRAC_BITS+1];
  logic [RW-1:0] dv_rem_r [T_FRAC_BITS+1];
  logic [SW-1:0] dv_vv_r  [T_FRAC_BITS+1];
  logic [DW-1:0] dv_x_r   [T_FRAC_BITS+1];
  logic [DW-1:0] dv_y_r   [T_FRAC_BITS+1];
  logic [DW-1:0] dv_z_r   [T_FRAC_BITS+1];

  logic          fix_nxt;
  logic [TW-1:0] fixq_nxt;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign q_in[0] = in_query_x;
  assign q_in[1] = in_query_y;
  assign q_in[2] = in_query_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) cfg_r[i] <= '0;
    end else if (cfg_we && (int'(cfg_index) < REG_COUNT)) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_c[i] = $signed({cfg_r[i][COORD_WIDTH-1], cfg_r[i]});
      d_c[i] = $signed({cfg_r[i+3][COORD_WIDTH-1], cfg_r[i+3]}) - s_c[i];
      w_c[i] = $signed({q_in[i][COORD_WIDTH-1], q_in[i]}) - s_c[i];
    end
    t_sat = (in_param_t > T_ONE) ? T_ONE : in_param_t;
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func_r <= func_t'(in_func);
      s1_t_r    <= t_sat;
      for (int i = 0; i < 3; i++) s1_w_r[i] <= w_c[i];
    end
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_func_r <= s1_func_r;
      for (int i = 0; i < 3; i++) begin
        s2_pt_r[i] <= $signed(d_c[i]) * $signed({1'b0, s1_t_r});
        s2_pw_r[i] <= $signed(s1_w_r[i]) * $signed(d_c[i]);
        s2_dd_r[i] <= $signed(d_c[i]) * $signed(d_c[i]);
      end
    end
  end

  // stage 3: sums and point or direction result
  always_comb begin
    logic signed [MTW-1:0] sh;
    num_nxt = '0;
    vv_nxt  = '0;
    for (int i = 0; i < 3; i++) begin
      sh = s2_pt_r[i] >>> T_FRAC_BITS;
      num_nxt = num_nxt + SW'(s2_pw_r[i]);
      vv_nxt  = vv_nxt + SW'(s2_dd_r[i]);
      case (s2_func_r)
        FUNC_POINT: res_nxt[i] = s_c[i] + sh[DW-1:0];
        FUNC_DIR:   res_nxt[i] = d_c[i];
        default:    res_nxt[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_func_r <= s2_func_r;
      s3_num_r  <= num_nxt;
      s3_vv_r   <= vv_nxt;
      for (int i = 0; i < 3; i++) s3_res_r[i] <= res_nxt[i];
    end
  end

  // classify: out of range, degenerate or needs division
  always_comb begin
    fix_nxt  = 1'b1;
    fixq_nxt = '0;
    if (s3_func_r == FUNC_PROJ) begin
      if (s3_vv_r <= SW'(DEGEN_RAW)) begin
        fixq_nxt = '0;
      end else if (s3_num_r <= 0) begin
        fixq_nxt = '0;
      end else if ($unsigned(s3_num_r) >= s3_vv_r) begin
        fixq_nxt = T_ONE;
      end else begin
        fix_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= T_FRAC_BITS; k++) dv_vld_r[k] <= 1'b0;
    end else if (adv) begin
      dv_vld_r[0] <= s3_vld_r;
      for (int k = 1; k <= T_FRAC_BITS; k++) dv_vld_r[k] <= dv_vld_r[k-1];
    end
  end

  // restoring division, one quotient bit per stage
  always_ff @(posedge clk) begin
    logic [RW-1:0] r2;
    if (adv) begin
      dv_fix_r[0] <= fix_nxt;
      dv_q_r[0]   <= fixq_nxt;
      dv_rem_r[0] <= RW'($unsigned(s3_num_r));
      dv_vv_r[0]  <= s3_vv_r;
      dv_x_r[0]   <= s3_res_r[0];
      dv_y_r[0]   <= s3_res_r[1];
      dv_z_r[0]   <= s3_res_r[2];
      for (int k = 1; k <= T_FRAC_BITS; k++) begin
        r2 = dv_rem_r[k-1] << 1;
        dv_fix_r[k] <= dv_fix_r[k-1];
        dv_vv_r[k]  <= dv_vv_r[k-1];
        dv_x_r[k]   <= dv_x_r[k-1];
        dv_y_r[k]   <= dv_y_r[k-1];
        dv_z_r[k]   <= dv_z_r[k-1];
        if (dv_fix_r[k-1]) begin
          dv_q_r[k]   <= dv_q_r[k-1];
          dv_rem_r[k] <= dv_rem_r[k-1];
        end else if (r2 >= {1'b0, dv_vv_r[k-1]}) begin
          dv_q_r[k]   <= {dv_q_r[k-1][TW-2:0], 1'b1};
          dv_rem_r[k] <= r2 - {1'b0, dv_vv_r[k-1]};
        end else begin
          dv_q_r[k]   <= {dv_q_r[k-1][TW-2:0], 1'b0};
          dv_rem_r[k] <= r2;
        end
      end
    end
  end

  assign out_valid = dv_vld_r[T_FRAC_BITS];
  assign out_res_x = dv_x_r[T_FRAC_BITS];
  assign out_res_y = dv_y_r[T_FRAC_BITS];
  assign out_res_z = dv_z_r[T_FRAC_BITS];
  assign out_res_t = dv_q_r[T_FRAC_BITS];

endmodule
